// ===== hw/rtl/rmj_pkg.sv =====
// Shared types and constants for the radar measurement Jacobian pipeline.
`default_nettype none

package rmj_pkg;

  // Quotient bits produced by each divider before rounding
  localparam int unsigned QUO_W   = 33;
  // Divider latency: operand stage, one stage per quotient bit, rounding stage
  localparam int unsigned DIV_LAT = QUO_W + 2;
  // Square root latency: one stage per result bit of a 64-bit radicand
  localparam int unsigned SQ_LAT  = 32;

  // Reset value of the range threshold, 0.0001 in units of 2^-32
  localparam logic [31:0] MIN_R2_RST = 32'd429497;
  localparam logic [31:0] POS_LIM    = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIM    = 32'h8000_0000;

  // Input word: constant-velocity state, signed Q16.16
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } rmj_in_t;

  // Output word: distinct Jacobian entries, signed Q16.16, plus flags
  typedef struct packed {
    logic signed [31:0] drange_dpx;
    logic signed [31:0] drange_dpy;
    logic signed [31:0] dbearing_dpx;
    logic signed [31:0] dbearing_dpy;
    logic signed [31:0] drate_dpx;
    logic signed [31:0] drate_dpy;
    logic               divide_error;
    logic               saturated;
  } rmj_out_t;

  // Rounded quotient magnitude and overflow mark from a divider
  typedef struct packed {
    logic             ovf;
    logic [QUO_W:0]   mag;
  } rmj_quo_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmj_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rmj_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output logic      [31:0] root
);

  logic [63:0] rad_q  [rmj_pkg::SQ_LAT];
  logic [33:0] rem_q  [rmj_pkg::SQ_LAT];
  logic [31:0] root_q [rmj_pkg::SQ_LAT];

  for (genvar i = 0; i < rmj_pkg::SQ_LAT; i++) begin : g_step
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in, rad_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= {rad_in[61:0], 2'b00};
        rem_q[i]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q[i] <= {root_in[30:0], ge};
      end
    end
  end

  assign root = root_q[rmj_pkg::SQ_LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rmj_div.sv =====
// Pipelined restoring divider with overflow precheck and round-half-up.
`default_nettype none

module rmj_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output rmj_pkg::rmj_quo_t     quo
);

  localparam int unsigned QW    = rmj_pkg::QUO_W;
  localparam int unsigned HI_W  = NUM_W - QW;
  localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem_q [QW+1];
  logic [QW-1:0]    lo_q  [QW+1];
  logic [QW-1:0]    q_q   [QW+1];
  logic [DEN_W-1:0] den_q [QW+1];
  logic             ovf_q [QW+1];

  logic [CMP_W-1:0] hi_ext;
  logic             rnd;

  // quotient of 2^QW or more cannot fit: flag it up front
  assign hi_ext = CMP_W'(num >> QW);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= DEN_W'(hi_ext);
      lo_q[0]  <= num[QW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den;
      ovf_q[0] <= hi_ext >= CMP_W'(den);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DEN_W:0] sh;
    logic           ge;

    assign sh = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign ge = sh >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DEN_W'(sh - {1'b0, den_q[k-1]}) : sh[DEN_W-1:0];
        lo_q[k]  <= {lo_q[k-1][QW-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QW-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // round half up on the remainder
  assign rnd = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo.ovf <= ovf_q[QW];
      quo.mag <= {1'b0, q_q[QW]} + (QW+1)'(rnd);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/radar_measurement_jacobian_top.sv =====
// Top level: radar measurement Jacobian, fully pipelined fixed-point datapath.
//
//  channel  | handshake                | word
//  ---------+--------------------------+---------------------------------
//  state    | state_valid / state_stall| rmj_in_t  (px, py, vx, vy)
//  jac      | jac_valid / jac_stall    | rmj_out_t (six entries, flags)
//  cfg      | cfg_we                   | cfg_wdata (min_range_squared)
//
// One word per cycle in while the output is not stalled. A word passes the front stages,
// the 32-stage square root, multiply and accumulate, the 35-stage dividers and the output.
// Synchronous active-high reset clears valid bits and loads the default threshold.
// A stalled output word freezes every stage; bubbles travel with the data and
// a word is accepted whenever the output register is free or being taken.
`default_nettype none

module radar_measurement_jacobian_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              state_valid,
  output logic                   state_stall,
  input  wire rmj_pkg::rmj_in_t  state_word,
  output logic                   jac_valid,
  input  wire logic              jac_stall,
  output rmj_pkg::rmj_out_t      jac_word
);

  localparam int unsigned SQL = rmj_pkg::SQ_LAT;
  localparam int unsigned DVL = rmj_pkg::DIV_LAT;

  typedef struct packed {
    logic        err;
    logic        sx;
    logic        sy;
    logic        cneg;
    logic [31:0] apx;
    logic [31:0] apy;
    logic [63:0] cmag;
    logic [63:0] r2;
  } sq_side_t;

  typedef struct packed {
    logic err;
    logic sx;
    logic sy;
    logic cneg;
  } flags_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } ent_t;

  logic        en;
  logic [31:0] min_r2;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_r2 <= rmj_pkg::MIN_R2_RST;
    end else if (cfg_we) begin
      min_r2 <= cfg_wdata;
    end
  end

  assign en          = !(jac_valid && jac_stall);
  assign state_stall = !en;

  // ---- stage 1: magnitudes and squares/products
  logic                v1, sx1, sy1;
  logic [31:0]         apx1, apy1;
  logic signed [63:0]  pxx1, pyy1, t1_1, t2_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= state_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= state_word.pos_x[31];
      sy1  <= state_word.pos_y[31];
      apx1 <= state_word.pos_x[31] ? 32'(-state_word.pos_x) : 32'(state_word.pos_x);
      apy1 <= state_word.pos_y[31] ? 32'(-state_word.pos_y) : 32'(state_word.pos_y);
      pxx1 <= 64'(state_word.pos_x) * 64'(state_word.pos_x);
      pyy1 <= 64'(state_word.pos_y) * 64'(state_word.pos_y);
      t1_1 <= 64'(state_word.vel_x) * 64'(state_word.pos_y);
      t2_1 <= 64'(state_word.vel_y) * 64'(state_word.pos_x);
    end
  end

  // ---- stage 2: r2 and cross term
  logic               v2, sx2, sy2;
  logic [31:0]        apx2, apy2;
  logic [63:0]        r2_2;
  logic signed [64:0] d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx2  <= sx1;
      sy2  <= sy1;
      apx2 <= apx1;
      apy2 <= apy1;
      r2_2 <= pxx1 + pyy1;
      d2   <= 65'(t1_1) - 65'(t2_1);
    end
  end

  // ---- stage 3: range guard, cross magnitude
  logic     v3;
  sq_side_t s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.err  <= (r2_2 < 64'(min_r2)) || (r2_2 == '0);
      s3.sx   <= sx2;
      s3.sy   <= sy2;
      s3.cneg <= d2[64];
      s3.cmag <= d2[64] ? 64'(-d2) : d2[63:0];
      s3.apx  <= apx2;
      s3.apy  <= apy2;
      s3.r2   <= r2_2;
    end
  end

  // ---- square root with matching side delay
  logic [31:0] root;
  logic        sq_v [SQL];
  sq_side_t    sq_d [SQL];

  rmj_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3.r2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQL; i++) sq_v[i] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v3;
      for (int i = 1; i < SQL; i++) sq_v[i] <= sq_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[0] <= s3;
      for (int i = 1; i < SQL; i++) sq_d[i] <= sq_d[i-1];
    end
  end

  // ---- multiply stage: 32x32 partial products
  logic        v4;
  flags_t      f4;
  logic [31:0] r4, apx4, apy4;
  logic [63:0] r2_4, pr_lo, pr_hi, py_lo, py_hi, px_lo, px_hi;
  sq_side_t    so;

  assign so = sq_d[SQL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_v[SQL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4    <= '{err: so.err, sx: so.sx, sy: so.sy, cneg: so.cneg};
      r4    <= root;
      r2_4  <= so.r2;
      apx4  <= so.apx;
      apy4  <= so.apy;
      pr_lo <= 64'(so.r2[31:0])  * 64'(root);
      pr_hi <= 64'(so.r2[63:32]) * 64'(root);
      py_lo <= 64'(so.apy) * 64'(so.cmag[31:0]);
      py_hi <= 64'(so.apy) * 64'(so.cmag[63:32]);
      px_lo <= 64'(so.apx) * 64'(so.cmag[31:0]);
      px_hi <= 64'(so.apx) * 64'(so.cmag[63:32]);
    end
  end

  // ---- accumulate stage: r3 and cross numerators
  logic        v5;
  flags_t      f5;
  logic [31:0] r5, apx5, apy5;
  logic [63:0] r2_5;
  logic [95:0] r3_5, cy5, cx5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f5   <= f4;
      r5   <= r4;
      r2_5 <= r2_4;
      apx5 <= apx4;
      apy5 <= apy4;
      r3_5 <= 96'(pr_lo) + {pr_hi, 32'b0};
      cy5  <= 96'(py_lo) + {py_hi, 32'b0};
      cx5  <= 96'(px_lo) + {px_hi, 32'b0};
    end
  end

  // ---- six dividers
  rmj_pkg::rmj_quo_t q0, q1, q2, q3, q4, q5;

  rmj_div #(.NUM_W(48), .DEN_W(32)) u_div0 (
    .clk(clk), .en(en), .num({apx5, 16'b0}), .den(r5), .quo(q0));
  rmj_div #(.NUM_W(48), .DEN_W(32)) u_div1 (
    .clk(clk), .en(en), .num({apy5, 16'b0}), .den(r5), .quo(q1));
  rmj_div #(.NUM_W(64), .DEN_W(64)) u_div2 (
    .clk(clk), .en(en), .num({apy5, 32'b0}), .den(r2_5), .quo(q2));
  rmj_div #(.NUM_W(64), .DEN_W(64)) u_div3 (
    .clk(clk), .en(en), .num({apx5, 32'b0}), .den(r2_5), .quo(q3));
  rmj_div #(.NUM_W(112), .DEN_W(96)) u_div4 (
    .clk(clk), .en(en), .num({cy5, 16'b0}), .den(r3_5), .quo(q4));
  rmj_div #(.NUM_W(112), .DEN_W(96)) u_div5 (
    .clk(clk), .en(en), .num({cx5, 16'b0}), .den(r3_5), .quo(q5));

  // flags ride alongside the dividers
  logic   dv_v [DVL];
  flags_t dv_f [DVL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DVL; i++) dv_v[i] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v5;
      for (int i = 1; i < DVL; i++) dv_v[i] <= dv_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_f[0] <= f5;
      for (int i = 1; i < DVL; i++) dv_f[i] <= dv_f[i-1];
    end
  end

  // apply sign and clip to Q16.16
  function automatic ent_t fix_sign(rmj_pkg::rmj_quo_t q, logic neg);
    ent_t e;
    e.sat = 1'b0;
    if (neg) begin
      if (q.ovf || q.mag > (rmj_pkg::QUO_W+1)'(rmj_pkg::NEG_LIM)) begin
        e.sat = 1'b1;
        e.val = rmj_pkg::NEG_LIM;
      end else begin
        e.val = -q.mag[31:0];
      end
    end else begin
      if (q.ovf || q.mag > (rmj_pkg::QUO_W+1)'(rmj_pkg::POS_LIM)) begin
        e.sat = 1'b1;
        e.val = rmj_pkg::POS_LIM;
      end else begin
        e.val = q.mag[31:0];
      end
    end
    return e;
  endfunction

  flags_t ff;
  ent_t   e0, e1, e2, e3, e4, e5;

  assign ff = dv_f[DVL-1];
  assign e0 = fix_sign(q0, ff.sx);
  assign e1 = fix_sign(q1, ff.sy);
  assign e2 = fix_sign(q2, !ff.sy);
  assign e3 = fix_sign(q3, ff.sx);
  assign e4 = fix_sign(q4, ff.sy ^ ff.cneg);
  assign e5 = fix_sign(q5, ff.sx ^ !ff.cneg);

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      jac_valid <= 1'b0;
    end else if (en) begin
      jac_valid <= dv_v[DVL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ff.err) begin
        jac_word.drange_dpx   <= '0;
        jac_word.drange_dpy   <= '0;
        jac_word.dbearing_dpx <= '0;
        jac_word.dbearing_dpy <= '0;
        jac_word.drate_dpx    <= '0;
        jac_word.drate_dpy    <= '0;
        jac_word.divide_error <= 1'b1;
        jac_word.saturated    <= 1'b0;
      end else begin
        jac_word.drange_dpx   <= e0.val;
        jac_word.drange_dpy   <= e1.val;
        jac_word.dbearing_dpx <= e2.val;
        jac_word.dbearing_dpy <= e3.val;
        jac_word.drate_dpx    <= e4.val;
        jac_word.drate_dpy    <= e5.val;
        jac_word.divide_error <= 1'b0;
        jac_word.saturated    <= e0.sat | e1.sat | e2.sat | e3.sat | e4.sat | e5.sat;
      end
    end
  end

  // ---- assertions
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    jac_valid && jac_word.divide_error |->
      !jac_word.saturated && jac_word.drange_dpx == 0 && jac_word.drate_dpy == 0)
    else $error("divide error word carries data");

  a_range_unit: assert property (@(posedge clk) disable iff (rst)
    jac_valid && !jac_word.divide_error |->
      jac_word.drange_dpx <= 32'sd65536 && jac_word.drange_dpx >= -32'sd65536 &&
      jac_word.drange_dpy <= 32'sd65536 && jac_word.drange_dpy >= -32'sd65536)
    else $error("range derivative exceeds unit magnitude");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    jac_valid && jac_word.saturated |->
      jac_word.dbearing_dpx == rmj_pkg::NEG_LIM || jac_word.dbearing_dpx == rmj_pkg::POS_LIM ||
      jac_word.dbearing_dpy == rmj_pkg::NEG_LIM || jac_word.dbearing_dpy == rmj_pkg::POS_LIM ||
      jac_word.drate_dpx == rmj_pkg::NEG_LIM || jac_word.drate_dpx == rmj_pkg::POS_LIM ||
      jac_word.drate_dpy == rmj_pkg::NEG_LIM || jac_word.drate_dpy == rmj_pkg::POS_LIM)
    else $error("saturated flag without a clipped entry");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    jac_valid && jac_stall |=> $stable(dv_v[DVL-1]) && jac_valid)
    else $error("pipeline moved under output stall");

endmodule

`default_nettype wire
